### rtl/ubst_pkg.sv
package ubst_pkg;

  localparam int CAPACITY   = 256;
  localparam int MAX_STATES = 64;

  localparam int SET_W = 64;
  localparam int SZ_W  = 7;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [SET_W-1:0] STORE_MASK = {SET_W{1'b1}} >> (SET_W - MAX_STATES);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_PUSH   = 2'd1,
    OP_FIND   = 2'd2,
    OP_POP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Broadcast to every cell; held steady while a token runs down the chain.
  typedef struct packed {
    op_t              op;
    logic [SET_W-1:0] query;
    logic [SET_W-1:0] mask;
    logic [CNT_W-1:0] count;
  } ubst_cmd_t;

  // Token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [SET_W-1:0] popped;
  } ubst_tok_t;

endpackage

### rtl/ubst_cell.sv
module ubst_cell
  import ubst_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] cell_idx,
  input  ubst_cmd_t        cmd,
  input  ubst_tok_t        tok_in,
  output ubst_tok_t        tok_out
);

  logic [SET_W-1:0] entry;
  logic             live;
  logic             hit;
  logic             first_hit;
  logic             write_en;
  logic             pop_take;

  always_comb begin
    live      = cell_idx < cmd.count;
    hit       = tok_in.valid && live && (((entry ^ cmd.query) & cmd.mask) == '0);
    first_hit = hit && !tok_in.found;
    // Every live entry lies before the cell at the fill level, so by the time
    // the token arrives there the search is complete.
    write_en  = tok_in.valid && (cell_idx == cmd.count) &&
                ((cmd.op == OP_PUSH) || ((cmd.op == OP_INSERT) && !tok_in.found));
    pop_take  = tok_in.valid && (cmd.op == OP_POP) &&
                ((cell_idx + CNT_W'(1)) == cmd.count);
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      entry <= cmd.query & STORE_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.found  <= tok_in.found | hit;
    tok_out.idx    <= first_hit ? cell_idx[IDX_W-1:0] : tok_in.idx;
    tok_out.popped <= pop_take ? entry : tok_in.popped;
  end

endmodule

### rtl/unique_bitset_stack_table_top.sv
// Deduplicating stack of 64-bit state sets, e.g. the worklist of a subset
// construction.
// Input stream: one beat carries an operation (insert if absent, push, find,
// pop) and a set. Output stream: one result beat per input beat, in order,
// with status, found flag, match index, popped set and the new entry count.
// The sets live in a row of CAPACITY cells, one entry each. Every operation
// sends a token down the row, one cell per cycle; each cell compares its entry
// with the query, the cell at the fill level takes a new set on a push or an
// insert that misses, and the top cell hands over its entry on a pop. One item
// is processed at a time: the next beat is accepted as soon as the result is
// loaded into the output register, even while the receiver stalls it; a
// stalled result holds. Reset empties the table (no clearing pass) and sets
// the compare width to 64. The compare width is written over the APB port at
// byte address 0; the user must write it only while idle, as the block itself
// does not enforce this.
module unique_bitset_stack_table_top
  import ubst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // func[1:0], set_bits[65:2]
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata   // status[1:0], found[2], match_index[10:3],
                                     // popped_set[74:11], entry_count[83:75],
                                     // is_empty[84]
);

  localparam logic REG_CMP_WIDTH = 1'b0;

  logic [SZ_W-1:0]  cmp_width;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             busy;
  logic             pending;
  logic             launch;
  ubst_cmd_t        cmd;
  ubst_tok_t        fin;
  ubst_tok_t        tok [0:CAPACITY];

  logic             in_beat;
  logic             load_out;
  logic             cfg_wr;
  status_t          res_status;
  logic             res_found;
  logic [IDX_W-1:0] res_idx;
  logic [SET_W-1:0] res_popped;

  function automatic logic [SET_W-1:0] cmp_mask(input logic [SZ_W-1:0] sz);
    logic [SZ_W-1:0] n;
    begin
      n = (sz > SZ_W'(MAX_STATES)) ? SZ_W'(MAX_STATES) : sz;
      cmp_mask = {SET_W{1'b1}} >> (SZ_W'(SET_W) - n);
    end
  endfunction

  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && pready && (paddr[2] == REG_CMP_WIDTH);
  assign prdata        = (paddr[2] == REG_CMP_WIDTH) ? {{(32 - SZ_W){1'b0}}, cmp_width} : '0;
  assign s_axis_tready = !busy;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign load_out      = pending && (!m_axis_tvalid || m_axis_tready);

  assign tok[0].valid  = launch;
  assign tok[0].found  = 1'b0;
  assign tok[0].idx    = '0;
  assign tok[0].popped = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ubst_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_idx(CNT_W'(g)),
      .cmd     (cmd),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  always_comb begin
    res_status = ST_OK;
    res_found  = 1'b0;
    res_idx    = '0;
    res_popped = '0;
    count_next = count;
    case (cmd.op)
      OP_INSERT: begin
        if (fin.found) begin
          res_found = 1'b1;
          res_idx   = fin.idx;
        end else if (count == CNT_W'(CAPACITY)) begin
          res_status = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      OP_PUSH: begin
        if (count == CNT_W'(CAPACITY)) begin
          res_status = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      OP_FIND: begin
        res_found = fin.found;
        res_idx   = fin.found ? fin.idx : '0;
      end
      OP_POP: begin
        if (count == '0) begin
          res_status = ST_EMPTY;
        end else begin
          count_next = count - CNT_W'(1);
          res_popped = fin.popped;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_width     <= SZ_W'(64);
      count         <= '0;
      busy          <= 1'b0;
      pending       <= 1'b0;
      launch        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        cmp_width <= pwdata[SZ_W-1:0];
      end
      launch <= in_beat;
      if (in_beat) begin
        busy <= 1'b1;
      end
      if (tok[CAPACITY].valid) begin
        pending <= 1'b1;
      end
      if (load_out) begin
        pending       <= 1'b0;
        busy          <= 1'b0;
        count         <= count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd.op    <= op_t'(s_axis_tdata[1:0]);
      cmd.query <= s_axis_tdata[65:2];
      cmd.mask  <= cmp_mask(cmp_width);
    end
    if (load_out) begin
      cmd.count <= count_next;
    end else if (!busy) begin
      cmd.count <= count;
    end
    if (tok[CAPACITY].valid) begin
      fin <= tok[CAPACITY];
    end
    if (load_out) begin
      m_axis_tdata <= {3'b000,
                       (count_next == '0),
                       9'(count_next),
                       res_popped,
                       8'(res_idx),
                       res_found,
                       res_status};
    end
  end

  assert property (@(posedge clk) disable iff (rst) tok[CAPACITY].valid |-> busy && !pending)
    else $error("token left the chain while no operation was in flight");

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  assert property (@(posedge clk) disable iff (rst) in_beat |=> launch && busy)
    else $error("accepted beat did not launch a token");

  assert property (@(posedge clk) disable iff (rst) !busy |-> !pending && !launch)
    else $error("idle with work outstanding");

endmodule

### verif/stack_table_checker.sv
module stack_table_checker
  import ubst_pkg::*;
#(
  parameter logic [2:0] SIZE_REG_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // func[1:0], set_bits[65:2]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [87:0] m_axis_tdata,  // status[1:0], found[2], match_index[10:3],
                                     // popped_set[74:11], entry_count[83:75],
                                     // is_empty[84]
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          peak_depth,
  output int          full_hits,
  output int          empty_pops,
  output int          match_hits
);

  typedef struct packed {
    status_t     status;
    logic        found;
    logic [7:0]  match_idx;
    logic [63:0] popped;
    logic [8:0]  entries;
    logic        empty;
  } stack_result_t;

  logic [63:0]   stack_mem [CAPACITY];
  int            depth;
  logic [6:0]    cmp_bits = 7'd64;
  stack_result_t expected_q [$];
  stack_result_t want;
  int            fails, seen, peak, n_full, n_empty, n_match;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    fails++;
    $display("result %0d: %s is %h, expected %h", seen, what, got, exp_val);
  endtask

  // Applies one operation to the shadow table and returns the result it should give.
  function automatic stack_result_t apply_stack_op(op_t op, logic [63:0] set_in);
    stack_result_t res;
    logic [63:0]   cmp_mask;
    logic [63:0]   keep_mask;
    int            width;
    int            hit;
    int            i;
    res.status    = ST_OK;
    res.found     = 1'b0;
    res.match_idx = '0;
    res.popped    = '0;
    width     = (cmp_bits > MAX_STATES) ? MAX_STATES : int'(cmp_bits);
    cmp_mask  = (width == 0) ? '0 : (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
    keep_mask = (MAX_STATES >= 64) ? '1 : ((64'd1 << MAX_STATES) - 64'd1);
    hit = -1;
    if (op == OP_INSERT || op == OP_FIND) begin
      for (i = 0; i < depth; i++) begin
        if (hit < 0 && ((stack_mem[i] ^ set_in) & cmp_mask) == '0) hit = i;
      end
    end
    if (hit >= 0) begin
      res.found     = 1'b1;
      res.match_idx = hit[7:0];
    end else if (op == OP_INSERT || op == OP_PUSH) begin
      if (depth >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        stack_mem[depth] = set_in & keep_mask;
        depth++;
      end
    end else if (op == OP_POP) begin
      if (depth == 0) begin
        res.status = ST_EMPTY;
      end else begin
        depth--;
        res.popped = stack_mem[depth];
      end
    end
    res.entries = depth[8:0];
    res.empty   = (depth == 0);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      depth    = 0;
      cmp_bits = 7'd64;
      expected_q.delete();
    end else begin
      // The result beat belongs to an older item, so it is checked before a new
      // item accepted at the same edge is predicted.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("beat with no result pending", m_axis_tdata[63:0], '0);
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata[1:0] != want.status)
            report_mismatch("status", 64'(m_axis_tdata[1:0]), 64'(want.status));
          if (m_axis_tdata[2] != want.found)
            report_mismatch("found", 64'(m_axis_tdata[2]), 64'(want.found));
          if (m_axis_tdata[10:3] != want.match_idx)
            report_mismatch("match_index", 64'(m_axis_tdata[10:3]), 64'(want.match_idx));
          if (m_axis_tdata[74:11] != want.popped)
            report_mismatch("popped_set", m_axis_tdata[74:11], want.popped);
          if (m_axis_tdata[83:75] != want.entries)
            report_mismatch("entry_count", 64'(m_axis_tdata[83:75]), 64'(want.entries));
          if (m_axis_tdata[84] != want.empty)
            report_mismatch("is_empty", 64'(m_axis_tdata[84]), 64'(want.empty));
          seen++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = apply_stack_op(op_t'(s_axis_tdata[1:0]), s_axis_tdata[65:2]);
        expected_q.push_back(want);
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_EMPTY) n_empty++;
        if (want.found) n_match++;
        if (depth > peak) peak = depth;
      end
      if (psel && penable && pready && paddr == SIZE_REG_ADDR) begin
        if (pwrite) begin
          cmp_bits = pwdata[6:0];
        end else if (prdata[6:0] != cmp_bits) begin
          report_mismatch("compare width readback", 64'(prdata), 64'(cmp_bits));
        end
      end
    end
    fail_count   <= fails;
    pending      <= expected_q.size();
    results_seen <= seen;
    peak_depth   <= peak;
    full_hits    <= n_full;
    empty_pops   <= n_empty;
    match_hits   <= n_match;
  end

endmodule

### verif/tb_top.sv
module tb_top;
  import ubst_pkg::*;

  localparam logic [2:0] SIZE_REG_ADDR   = 3'd0;
  localparam int         LATENCY         = CAPACITY + 3;
  localparam int         HOLD_OFF_CYCLES = 3 * LATENCY;
  localparam int         WATCHDOG_LIMIT  = 16 * LATENCY;
  localparam int         NUM_PHASES      = 7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // func[1:0], set_bits[65:2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;       // status[1:0], found[2], match_index[10:3],
                                   // popped_set[74:11], entry_count[83:75],
                                   // is_empty[84]

  int fail_count, pending, results_seen, peak_depth, full_hits, empty_pops, match_hits;
  int beats_sent;
  int quiet_cycles;
  logic [63:0] recent_sets [$];

  // Per phase: compare width, item count and operation weights
  // (insert, push, find, pop) in percent.
  int phase_size [NUM_PHASES] = '{64, 8, 1, 127, 33, 0, 64};
  int phase_len  [NUM_PHASES] = '{450, 120, 150, 120, 100, 60, 100};
  int phase_w    [NUM_PHASES][4] = '{'{30, 55, 10, 5}, '{25, 25, 25, 25}, '{8, 12, 10, 70},
                                     '{8, 12, 10, 70}, '{25, 25, 25, 25}, '{8, 12, 10, 70},
                                     '{8, 12, 10, 70}};

  always #6 clk = ~clk;

  unique_bitset_stack_table_top dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  stack_table_checker #(
    .SIZE_REG_ADDR (SIZE_REG_ADDR)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .peak_depth    (peak_depth),
    .full_hits     (full_hits),
    .empty_pops    (empty_pops),
    .match_hits    (match_hits)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  // Half the time sets seen recently (or one bit away from them) so that searches hit.
  function automatic logic [63:0] pick_set();
    int          r;
    logic [63:0] one_bit;
    logic [63:0] seen_set;
    r        = $urandom_range(0, 99);
    one_bit  = 64'd1 << $urandom_range(0, 63);
    seen_set = (recent_sets.size() == 0) ? '0 :
               recent_sets[$urandom_range(0, recent_sets.size() - 1)];
    if (r < 35) return seen_set;
    if (r < 50) return seen_set ^ one_bit;
    if (r < 65) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return '1;
        2:       return one_bit;
        default: return ~one_bit;
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  task automatic send_beat(op_t op, logic [63:0] bits);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, bits, op};
    do @(posedge clk); while (!s_axis_tready);
    beats_sent++;
    recent_sets.push_back(bits);
    if (recent_sets.size() > 32) void'(recent_sets.pop_front());
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Steps the clock first so that a beat just accepted shows in the pending count.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic apb_access(logic write, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= SIZE_REG_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_compare_width(int bits);
    drain();
    apb_access(1'b1, 32'(bits));
    apb_access(1'b0, '0);
  endtask

  initial begin
    int   p, k, r;
    op_t  op;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_access(1'b0, '0);

    // Empty table, duplicates, extreme sets, then pops past the bottom.
    send_beat(OP_POP, '0);
    send_beat(OP_FIND, '1);
    send_beat(OP_INSERT, '1);
    send_beat(OP_INSERT, '0);
    send_beat(OP_INSERT, '1);
    send_beat(OP_PUSH, '1);
    send_beat(OP_FIND, '0);
    send_beat(OP_INSERT, 64'h8000_0000_0000_0000);
    send_beat(OP_INSERT, 64'h0000_0000_0000_0001);
    send_beat(OP_FIND, 64'h8000_0000_0000_0000);
    send_beat(OP_FIND, 64'hA5A5_5A5A_0F0F_F0F0);
    repeat (6) send_beat(OP_POP, '0);

    // With no bits compared everything matches the first entry.
    set_compare_width(0);
    send_beat(OP_INSERT, 64'h0000_0000_0000_1234);
    send_beat(OP_INSERT, 64'h0000_0000_FFFF_0000);
    send_beat(OP_FIND, 64'h0000_0000_0000_DEAD);
    send_beat(OP_POP, '0);

    // An oversized width behaves as the full 64 bits.
    set_compare_width(127);
    send_beat(OP_INSERT, 64'h8000_0000_0000_0000);
    send_beat(OP_FIND, '0);
    send_beat(OP_POP, '0);

    for (p = 0; p < NUM_PHASES; p++) begin
      set_compare_width(phase_size[p]);
      for (k = 0; k < phase_len[p]; k++) begin
        r = $urandom_range(0, 99);
        if (r < phase_w[p][0]) op = OP_INSERT;
        else if (r < phase_w[p][0] + phase_w[p][1]) op = OP_PUSH;
        else if (r < phase_w[p][0] + phase_w[p][1] + phase_w[p][2]) op = OP_FIND;
        else op = OP_POP;
        send_beat(op, pick_set());
      end
    end

    drain();
    repeat (LATENCY + 16) @(posedge clk);
    $display("Sent %0d beats across compare widths 64, 0, 127, 8, 1 and 33; %0d results checked.",
             beats_sent, results_seen);
    $display("Table peaked at %0d entries; %0d full rejections, %0d empty pops, %0d matches.",
             peak_depth, full_hits, empty_pops, match_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Result side: ready stretches broken by stalls, plus a long hold-off now and then
  // so that the output register fills and the input stalls.
  initial begin
    int next_hold_at;
    int g;
    next_hold_at = 60;
    wait (!rst);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 20)) @(posedge clk);
      if (results_seen >= next_hold_at) begin
        next_hold_at += 500;
        g = HOLD_OFF_CYCLES;
      end else begin
        g = pick_gap();
      end
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("No beat moved for %0d cycles.", quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
